### design/ohlc_trade_aggregator_core_macros.svh
// ----------------------------------------------------------------------------
// ohlc_trade_aggregator_core_macros
// Assertion macros used by the checker of the trade aggregator.
// ----------------------------------------------------------------------------
`ifndef OHLC_TRADE_AGGREGATOR_CORE_MACROS_SVH
`define OHLC_TRADE_AGGREGATOR_CORE_MACROS_SVH

// Check a same-cycle implication on every clock edge outside reset
`define OHLC_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check an implication in the next cycle on every clock edge outside reset
`define OHLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ohlc_pkg.sv
// ----------------------------------------------------------------------------
// ohlc_pkg
// Shared types and widths of the OHLCV trade aggregator.
// ----------------------------------------------------------------------------
package ohlc_pkg;

   localparam int unsigned PriceWidth   = 32;
   localparam int unsigned SumWidth     = 64;
   localparam int unsigned ReqDataWidth = 96;
   localparam int unsigned RspDataWidth = 448;

   // One trade after the product stage
   typedef struct packed {
      logic [PriceWidth-1:0] price;
      logic [PriceWidth-1:0] volume;
      logic [PriceWidth-1:0] seq_index;
      logic                  last;
      logic [SumWidth-1:0]   price_sq;
      logic [SumWidth-1:0]   volume_sq;
   } trade_type;

   // One finished candlestick record
   typedef struct packed {
      logic [PriceWidth-1:0] open_price;
      logic [PriceWidth-1:0] high_price;
      logic [PriceWidth-1:0] low_price;
      logic [PriceWidth-1:0] close_price;
      logic [SumWidth-1:0]   volume_total;
      logic [PriceWidth-1:0] trade_count;
      logic [SumWidth-1:0]   price_total;
      logic [SumWidth-1:0]   price_square_total;
      logic [SumWidth-1:0]   volume_square_total;
      logic [PriceWidth-1:0] open_seq;
   } record_type;

endpackage

### design/ohlc_front.sv
// ----------------------------------------------------------------------------
// ohlc_front
// Accepts trades and registers them together with the price and volume squares.
// ----------------------------------------------------------------------------
module ohlc_front
   import ohlc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PriceWidth-1:0] req_price,
   input  logic [PriceWidth-1:0] req_volume,
   input  logic [PriceWidth-1:0] req_seq_index,
   input  logic                  req_last,
   output logic                  push_valid,
   input  logic                  push_ready,
   output trade_type             push_item
);

   logic      stage_valid_ff;
   logic      stage_valid_in;
   trade_type stage_item_ff;
   logic      accept;

   // Take a new trade whenever the stage is empty or drains this cycle
   assign req_ready = !stage_valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Square price and volume, one multiplier each, registered
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff.price     <= req_price;
         stage_item_ff.volume    <= req_volume;
         stage_item_ff.seq_index <= req_seq_index;
         stage_item_ff.last      <= req_last;
         stage_item_ff.price_sq  <= SumWidth'(req_price) * SumWidth'(req_price);
         stage_item_ff.volume_sq <= SumWidth'(req_volume) * SumWidth'(req_volume);
      end
   end

   assign push_valid = stage_valid_ff;
   assign push_item  = stage_item_ff;

endmodule

### design/ohlc_queue.sv
// ----------------------------------------------------------------------------
// ohlc_queue
// Short FIFO of trades between the product stage and the accumulators.
// ----------------------------------------------------------------------------
module ohlc_queue
   import ohlc_pkg::*;
#(
   parameter int unsigned Depth = 4
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  trade_type push_item,
   output logic      pop_valid,
   input  logic      pop_ready,
   output trade_type pop_item
);

   localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);

   trade_type               entries_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff;
   logic [PtrWidth-1:0]     wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff;
   logic [PtrWidth-1:0]     rd_ptr_in;
   logic [CountWidth-1:0]   count_ff;
   logic [CountWidth-1:0]   count_in;
   logic                    push;
   logic                    pop;

   assign push_ready = (count_ff != CountWidth'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entries_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/ohlc_back.sv
// ----------------------------------------------------------------------------
// ohlc_back
// Updates the run accumulators and holds the finished record for the receiver.
// ----------------------------------------------------------------------------
module ohlc_back
   import ohlc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  trade_type  pop_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output record_type rsp_record
);

   logic                  run_start_ff;
   logic                  run_start_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   record_type            rsp_record_ff;
   record_type            acc_ff;
   record_type            acc_in;
   logic [PriceWidth-1:0] close_idx_ff;
   logic [PriceWidth-1:0] close_idx_in;
   logic                  out_free;
   logic                  fire;

   function automatic logic [SumWidth-1:0] sat_add(input logic [SumWidth-1:0] a,
                                                   input logic [SumWidth-1:0] b);
      logic [SumWidth:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[SumWidth] ? '1 : sum[SumWidth-1:0];
   endfunction

   // Stall only a run-closing trade while the record slot is still occupied
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = !pop_item.last || out_free;
   assign fire      = pop_valid && pop_ready;

   // Start a fresh run or fold the trade into the current one
   always_comb begin
      acc_in       = acc_ff;
      close_idx_in = close_idx_ff;
      if (run_start_ff) begin
         acc_in.open_price          = pop_item.price;
         acc_in.high_price          = pop_item.price;
         acc_in.low_price           = pop_item.price;
         acc_in.close_price         = pop_item.price;
         acc_in.open_seq            = pop_item.seq_index;
         close_idx_in               = pop_item.seq_index;
         acc_in.trade_count         = PriceWidth'(1);
         acc_in.volume_total        = SumWidth'(pop_item.volume);
         acc_in.volume_square_total = pop_item.volume_sq;
         acc_in.price_total         = SumWidth'(pop_item.price);
         acc_in.price_square_total  = pop_item.price_sq;
      end else begin
         if (pop_item.seq_index < acc_ff.open_seq) begin
            acc_in.open_price = pop_item.price;
            acc_in.open_seq   = pop_item.seq_index;
         end
         if (pop_item.seq_index > close_idx_ff) begin
            acc_in.close_price = pop_item.price;
            close_idx_in       = pop_item.seq_index;
         end
         if (pop_item.price > acc_ff.high_price) begin
            acc_in.high_price = pop_item.price;
         end
         if (pop_item.price < acc_ff.low_price) begin
            acc_in.low_price = pop_item.price;
         end
         acc_in.volume_total        = sat_add(acc_ff.volume_total,
                                              SumWidth'(pop_item.volume));
         acc_in.volume_square_total = sat_add(acc_ff.volume_square_total,
                                              pop_item.volume_sq);
         acc_in.price_total         = sat_add(acc_ff.price_total,
                                              SumWidth'(pop_item.price));
         acc_in.price_square_total  = sat_add(acc_ff.price_square_total,
                                              pop_item.price_sq);
         if (acc_ff.trade_count != '1) begin
            acc_in.trade_count = acc_ff.trade_count + 1'b1;
         end
      end
   end

   // Control: run start flag and record slot
   always_comb begin
      run_start_in = run_start_ff;
      if (fire) begin
         run_start_in = pop_item.last;
      end
      if (fire && pop_item.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_start_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_start_ff <= run_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold accumulators and load the record on a run-closing trade
   always_ff @(posedge clock) begin
      if (fire) begin
         acc_ff       <= acc_in;
         close_idx_ff <= close_idx_in;
         if (pop_item.last) begin
            rsp_record_ff <= acc_in;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_record = rsp_record_ff;

endmodule

### design/ohlc_trade_aggregator_core.sv
// ----------------------------------------------------------------------------
// ohlc_trade_aggregator_core
// OHLCV candlestick aggregation over runs of trades in unsigned integer ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Trades enter on the req_ stream, one per transaction; req_tlast marks the
//   trade that closes a run. For each closed run one candlestick record leaves
//   on the rsp_ stream; trades that do not close a run produce no transaction.
//   Throughput: one trade per clock cycle, sustained while the receiver does
//   not stall a record, set by the two 32x32 squaring multipliers in the front
//   stage and the accumulator update in the back stage.
//   Path: the record shows on rsp_tvalid once the closing trade has passed the
//   product register, then the queue and the accumulators.
//   Reset: the queue and the record slot empty, and the next trade opens a run.
//   Stall: a stalled receiver holds the record; the back stage keeps folding
//   trades that do not close a run, the queue (QueueDepth entries) fills, and
//   req_tready drops only once the queue and the product stage are full.
// ----------------------------------------------------------------------------
module ohlc_trade_aggregator_core
   import ohlc_pkg::*;
#(
   parameter int unsigned QueueDepth = 4
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // price [31:0], volume [63:32], seq_index [95:64]
   input  logic [ReqDataWidth-1:0] req_tdata,
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // open_price [31:0], high_price [63:32], low_price [95:64],
   // close_price [127:96], volume_total [191:128], trade_count [223:192],
   // price_total [287:224], price_square_total [351:288],
   // volume_square_total [415:352], open_seq [447:416]
   output logic [RspDataWidth-1:0] rsp_tdata
);

   logic       push_valid;
   logic       push_ready;
   trade_type  push_item;
   logic       pop_valid;
   logic       pop_ready;
   trade_type  pop_item;
   record_type rsp_record;

   ohlc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_price     (req_tdata[31:0]),
      .req_volume    (req_tdata[63:32]),
      .req_seq_index (req_tdata[95:64]),
      .req_last      (req_tlast),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   ohlc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   ohlc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_record (rsp_record)
   );

   // Pack the record, first field in the lowest bits
   assign rsp_tdata = {rsp_record.open_seq,
                       rsp_record.volume_square_total,
                       rsp_record.price_square_total,
                       rsp_record.price_total,
                       rsp_record.trade_count,
                       rsp_record.volume_total,
                       rsp_record.close_price,
                       rsp_record.low_price,
                       rsp_record.high_price,
                       rsp_record.open_price};

endmodule

### design/ohlc_checker.sv
// ----------------------------------------------------------------------------
// ohlc_checker
// Port-level checks of the trade aggregator, bound to the top level.
// ----------------------------------------------------------------------------
`include "ohlc_trade_aggregator_core_macros.svh"

module ohlc_checker
   import ohlc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata
);

   logic [PriceWidth-1:0] open_price;
   logic [PriceWidth-1:0] high_price;
   logic [PriceWidth-1:0] low_price;
   logic [PriceWidth-1:0] close_price;
   logic [PriceWidth-1:0] trade_count;

   assign open_price  = rsp_tdata[31:0];
   assign high_price  = rsp_tdata[63:32];
   assign low_price   = rsp_tdata[95:64];
   assign close_price = rsp_tdata[127:96];
   assign trade_count = rsp_tdata[223:192];

   // A stalled record holds
   `OHLC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "record changed while stalled")

   // Every record counts at least one trade
   `OHLC_ASSERT_HOLDS(a_count_nonzero, rsp_tvalid, trade_count != '0,
      "record with zero trades")

   // Open and close lie between low and high
   `OHLC_ASSERT_HOLDS(a_price_order, rsp_tvalid,
      (low_price <= open_price) && (open_price <= high_price) &&
      (low_price <= close_price) && (close_price <= high_price),
      "open or close outside low..high")

   // No record can come out within the first cycles after reset
   `OHLC_ASSERT_NEXT(a_quiet_after_reset, $fell(reset), !rsp_tvalid ##1 !rsp_tvalid,
      "record appeared too early after reset")

   // The input side is open right after reset
   `OHLC_ASSERT_HOLDS(a_ready_after_reset, $fell(reset), req_tready,
      "input not ready after reset")

endmodule

bind ohlc_trade_aggregator_core ohlc_checker u_checker (.*);
